@@ design/prsq_pkg.sv @@
`default_nettype none

package prsq_pkg;

  localparam int MAX_ATOMS = 64;
  localparam int ELEM_BITS = 16;

  localparam int CFG_BITS  = 7;
  localparam int SUM_BITS  = 36;
  localparam int ATOM_BITS = $clog2(MAX_ATOMS);
  localparam int COL_BITS  = ATOM_BITS + 1;
  localparam int PROD_BITS = 2 * COL_BITS;
  localparam int PAIR_BITS = $clog2(MAX_ATOMS * (MAX_ATOMS - 1) / 2 + 1);
  localparam int SQ_BITS   = 2 * ELEM_BITS;
  localparam int ADD_BITS  = ((SQ_BITS > SUM_BITS) ? SQ_BITS : SUM_BITS) + 1;

  localparam logic [CFG_BITS-1:0] ATOM_COUNT_RESET = CFG_BITS'(2);
  localparam logic [SUM_BITS-1:0] SUM_MAX          = '1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_WRA  = 5'b00010,
    ST_WRB  = 5'b00100,
    ST_ERD  = 5'b01000,
    ST_ELD  = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic [ATOM_BITS-1:0] rd_addr_a;
    logic [ATOM_BITS-1:0] rd_addr_b;
    logic [ATOM_BITS-1:0] wr_addr;
    logic                 wr_en;
    logic                 wr_sel_b;
    logic                 sq_load;
    logic                 out_load;
    logic [ATOM_BITS-1:0] out_index;
    logic                 out_final;
    logic                 out_mismatch;
    logic                 clear_all;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ design/pair_row_square_sum_unit.sv @@
// channel   direction  handshake           payload
// cfg       in         cfg_wr_en           cfg_wr_data (atom count, 7 bits)
// in        in         in_valid/in_stall   in_element, in_vector_end
// out       out        out_valid/out_stall out_atom_index, out_row_sum,
//                                          out_final_atom, out_count_mismatch
// Each element beat is one read of both atom sums from the sum RAM, then one write per
// atom (row, then column), since the RAM has a single write port.
// A vector-end beat is followed by an output sweep: per atom, a RAM read and then a load
// of the output register, which waits while out_stall holds the output register.
// Reset is synchronous; per-atom valid bits make the sum RAM read as zero after reset
// and after each vector, so there is no clearing pass.
// in_stall is high from an accepted beat until its work and any output sweep are done.
`default_nettype none

module pair_row_square_sum_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [prsq_pkg::CFG_BITS-1:0]         cfg_wr_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [prsq_pkg::ELEM_BITS-1:0] in_element,
  input  wire logic                                  in_vector_end,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [prsq_pkg::ATOM_BITS-1:0]             out_atom_index,
  output logic [prsq_pkg::SUM_BITS-1:0]              out_row_sum,
  output logic                                       out_final_atom,
  output logic                                       out_count_mismatch
);

  prsq_pkg::dp_cmd_t cmd;
  prsq_pkg::dp_sts_t sts;

  prsq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vector_end (in_vector_end),
    .sts           (sts),
    .cmd           (cmd)
  );

  prsq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_element         (in_element),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_atom_index     (out_atom_index),
    .out_row_sum        (out_row_sum),
    .out_final_atom     (out_final_atom),
    .out_count_mismatch (out_count_mismatch)
  );

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> in_stall)
    else $error("sum RAM write while accepting beats");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

  a_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.wr_sel_b) |-> $past(cmd.wr_en && !cmd.wr_sel_b))
    else $error("column update without preceding row update");

  a_pair_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (cmd.rd_addr_a != cmd.rd_addr_b))
    else $error("pair update with equal row and column atom");

endmodule

`default_nettype wire

@@ design/prsq_ram.sv @@
`default_nettype none

module prsq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wa,
  input  wire logic [WIDTH-1:0] wd,
  input  wire logic [AW-1:0]    ra0,
  output logic      [WIDTH-1:0] rd0,
  input  wire logic [AW-1:0]    ra1,
  output logic      [WIDTH-1:0] rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

`default_nettype wire

@@ design/prsq_ctrl.sv @@
`default_nettype none

module prsq_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [prsq_pkg::CFG_BITS-1:0]     cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_vector_end,
  input  wire prsq_pkg::dp_sts_t                 sts,
  output prsq_pkg::dp_cmd_t                      cmd
);

  prsq_pkg::ctrl_state_t state_r, state_nxt;

  logic [prsq_pkg::CFG_BITS-1:0]  atom_count_r;
  logic [prsq_pkg::ATOM_BITS-1:0] row_pos_r, row_pos_nxt;
  logic [prsq_pkg::COL_BITS-1:0]  col_pos_r, col_pos_nxt;
  logic [prsq_pkg::PAIR_BITS-1:0] pairs_r, pairs_nxt;
  logic                           ovf_r, ovf_nxt;
  logic                           hit_r, hit_nxt;
  logic                           vend_r, vend_nxt;
  logic                           mism_r, mism_nxt;
  logic [prsq_pkg::ATOM_BITS-1:0] wa_row_r, wa_row_nxt;
  logic [prsq_pkg::ATOM_BITS-1:0] wa_col_r, wa_col_nxt;
  logic [prsq_pkg::ATOM_BITS-1:0] emit_idx_r, emit_idx_nxt;

  logic [prsq_pkg::COL_BITS-1:0]  n_w;
  logic [prsq_pkg::PROD_BITS-1:0] npp_w;
  logic [prsq_pkg::PAIR_BITS-1:0] npairs_w;
  logic                           accept_w;
  logic                           hit_w;
  logic                           emit_last_w;

  always_comb begin
    if (atom_count_r < prsq_pkg::CFG_BITS'(2)) begin
      n_w = prsq_pkg::COL_BITS'(2);
    end else if (atom_count_r > prsq_pkg::CFG_BITS'(prsq_pkg::MAX_ATOMS)) begin
      n_w = prsq_pkg::COL_BITS'(prsq_pkg::MAX_ATOMS);
    end else begin
      n_w = prsq_pkg::COL_BITS'(atom_count_r);
    end
  end

  assign npp_w    = prsq_pkg::PROD_BITS'(n_w)
                  * prsq_pkg::PROD_BITS'(n_w - prsq_pkg::COL_BITS'(1));
  assign npairs_w = prsq_pkg::PAIR_BITS'(npp_w >> 1);

  assign in_stall = (state_r != prsq_pkg::ST_IDLE);
  assign accept_w = in_valid && (state_r == prsq_pkg::ST_IDLE);

  assign hit_w = (pairs_r < npairs_w)
              && ((prsq_pkg::COL_BITS'(row_pos_r) + prsq_pkg::COL_BITS'(1)) < n_w)
              && (col_pos_r < n_w);

  assign emit_last_w = (prsq_pkg::COL_BITS'(emit_idx_r) + prsq_pkg::COL_BITS'(1)) == n_w;

  always_comb begin
    state_nxt    = state_r;
    row_pos_nxt  = row_pos_r;
    col_pos_nxt  = col_pos_r;
    pairs_nxt    = pairs_r;
    ovf_nxt      = ovf_r;
    hit_nxt      = hit_r;
    vend_nxt     = vend_r;
    mism_nxt     = mism_r;
    wa_row_nxt   = wa_row_r;
    wa_col_nxt   = wa_col_r;
    emit_idx_nxt = emit_idx_r;

    cmd              = '0;
    cmd.rd_addr_a    = wa_row_r;
    cmd.rd_addr_b    = wa_col_r;
    cmd.wr_addr      = wa_row_r;
    cmd.out_index    = emit_idx_r;
    cmd.out_final    = emit_last_w;
    cmd.out_mismatch = mism_r;

    case (state_r)
      prsq_pkg::ST_IDLE: begin
        cmd.rd_addr_a = row_pos_r;
        cmd.rd_addr_b = col_pos_r[prsq_pkg::ATOM_BITS-1:0];
        if (accept_w) begin
          cmd.sq_load = 1'b1;
          hit_nxt     = hit_w;
          vend_nxt    = in_vector_end;
          wa_row_nxt  = row_pos_r;
          wa_col_nxt  = col_pos_r[prsq_pkg::ATOM_BITS-1:0];
          if (hit_w) begin
            pairs_nxt = pairs_r + prsq_pkg::PAIR_BITS'(1);
            if ((col_pos_r + prsq_pkg::COL_BITS'(1)) >= n_w) begin
              row_pos_nxt = row_pos_r + prsq_pkg::ATOM_BITS'(1);
              col_pos_nxt = prsq_pkg::COL_BITS'(row_pos_r) + prsq_pkg::COL_BITS'(2);
            end else begin
              col_pos_nxt = col_pos_r + prsq_pkg::COL_BITS'(1);
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          mism_nxt  = ovf_r || !hit_w || (pairs_nxt != npairs_w);
          state_nxt = prsq_pkg::ST_WRA;
        end
      end
      prsq_pkg::ST_WRA: begin
        cmd.wr_en   = hit_r;
        cmd.wr_addr = wa_row_r;
        state_nxt   = prsq_pkg::ST_WRB;
      end
      prsq_pkg::ST_WRB: begin
        cmd.wr_en    = hit_r;
        cmd.wr_sel_b = 1'b1;
        cmd.wr_addr  = wa_col_r;
        if (vend_r) begin
          emit_idx_nxt = '0;
          state_nxt    = prsq_pkg::ST_ERD;
        end else begin
          state_nxt = prsq_pkg::ST_IDLE;
        end
      end
      prsq_pkg::ST_ERD: begin
        cmd.rd_addr_a = emit_idx_r;
        state_nxt     = prsq_pkg::ST_ELD;
      end
      prsq_pkg::ST_ELD: begin
        cmd.rd_addr_a = emit_idx_r;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (emit_last_w) begin
            cmd.clear_all = 1'b1;
            row_pos_nxt   = '0;
            col_pos_nxt   = prsq_pkg::COL_BITS'(1);
            pairs_nxt     = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = prsq_pkg::ST_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + prsq_pkg::ATOM_BITS'(1);
            state_nxt    = prsq_pkg::ST_ERD;
          end
        end
      end
      default: begin
        state_nxt = prsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prsq_pkg::ST_IDLE;
      atom_count_r <= prsq_pkg::ATOM_COUNT_RESET;
      row_pos_r    <= '0;
      col_pos_r    <= prsq_pkg::COL_BITS'(1);
      pairs_r      <= '0;
      ovf_r        <= 1'b0;
      hit_r        <= 1'b0;
      vend_r       <= 1'b0;
      mism_r       <= 1'b0;
      emit_idx_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      row_pos_r  <= row_pos_nxt;
      col_pos_r  <= col_pos_nxt;
      pairs_r    <= pairs_nxt;
      ovf_r      <= ovf_nxt;
      hit_r      <= hit_nxt;
      vend_r     <= vend_nxt;
      mism_r     <= mism_nxt;
      emit_idx_r <= emit_idx_nxt;
      if (cfg_wr_en) begin
        atom_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa_row_r <= wa_row_nxt;
    wa_col_r <= wa_col_nxt;
  end

endmodule

`default_nettype wire

@@ design/prsq_dp.sv @@
`default_nettype none

module prsq_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic signed [prsq_pkg::ELEM_BITS-1:0] in_element,
  input  wire prsq_pkg::dp_cmd_t                     cmd,
  output prsq_pkg::dp_sts_t                          sts,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [prsq_pkg::ATOM_BITS-1:0]             out_atom_index,
  output logic [prsq_pkg::SUM_BITS-1:0]              out_row_sum,
  output logic                                       out_final_atom,
  output logic                                       out_count_mismatch
);

  logic [prsq_pkg::SQ_BITS-1:0]   sq_r;
  logic [prsq_pkg::MAX_ATOMS-1:0] valid_r;
  logic                           vld_a_r, vld_b_r;
  logic [prsq_pkg::SUM_BITS-1:0]  rd_a, rd_b;
  logic [prsq_pkg::SUM_BITS-1:0]  base_a_w, base_b_w, base_w;
  logic [prsq_pkg::ADD_BITS-1:0]  sum_w;
  logic [prsq_pkg::SUM_BITS-1:0]  wr_data_w;
  logic signed [prsq_pkg::SQ_BITS-1:0] prod_w;

  logic                           out_valid_r;
  logic [prsq_pkg::ATOM_BITS-1:0] out_index_r;
  logic [prsq_pkg::SUM_BITS-1:0]  out_sum_r;
  logic                           out_final_r;
  logic                           out_mism_r;

  assign prod_w = in_element * in_element;

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq_r <= $unsigned(prod_w);
    end
  end

  prsq_ram #(
    .WIDTH (prsq_pkg::SUM_BITS),
    .DEPTH (prsq_pkg::MAX_ATOMS)
  ) u_sums (
    .clk (clk),
    .we  (cmd.wr_en),
    .wa  (cmd.wr_addr),
    .wd  (wr_data_w),
    .ra0 (cmd.rd_addr_a),
    .rd0 (rd_a),
    .ra1 (cmd.rd_addr_b),
    .rd1 (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= valid_r[cmd.rd_addr_a];
      vld_b_r <= valid_r[cmd.rd_addr_b];
      if (cmd.clear_all) begin
        valid_r <= '0;
      end else if (cmd.wr_en) begin
        valid_r[cmd.wr_addr] <= 1'b1;
      end
    end
  end

  assign base_a_w = vld_a_r ? rd_a : '0;
  assign base_b_w = vld_b_r ? rd_b : '0;
  assign base_w   = cmd.wr_sel_b ? base_b_w : base_a_w;
  assign sum_w    = prsq_pkg::ADD_BITS'(base_w) + prsq_pkg::ADD_BITS'(sq_r);

  assign wr_data_w = (sum_w > prsq_pkg::ADD_BITS'(prsq_pkg::SUM_MAX))
                   ? prsq_pkg::SUM_MAX : sum_w[prsq_pkg::SUM_BITS-1:0];

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index_r <= cmd.out_index;
      out_sum_r   <= base_a_w;
      out_final_r <= cmd.out_final;
      out_mism_r  <= cmd.out_mismatch;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_atom_index     = out_index_r;
  assign out_row_sum        = out_sum_r;
  assign out_final_atom     = out_final_r;
  assign out_count_mismatch = out_mism_r;

endmodule

`default_nettype wire

@@ test/pair_row_square_sum_unit_tb.sv @@
`default_nettype none

module pair_row_square_sum_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prsq_pkg::*;

  localparam int RAND_ITEMS    = 140;
  localparam int PHASE_ITEMS   = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 200;
  localparam int LONG_HOLD     = 300;
  localparam int TIMEOUT_NS    = 1_000_000;
  localparam int DIR_ROWS      = 19;
  localparam int NUM_PHASES    = 10;

  typedef struct packed {
    logic [ATOM_BITS-1:0] atom_index;
    logic [SUM_BITS-1:0]  row_sum;
    logic                 final_atom;
    logic                 count_mismatch;
  } row_result_t;

  typedef struct {
    int                  cfg;
    logic [ELEM_BITS-1:0] elem;
    bit                  vend;
    bit                  typed;
    logic [SUM_BITS-1:0] t_sum;
    bit                  t_mis;
  } dir_row_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_t;
  typedef enum int {VEC_WHOLE, VEC_SHORT, VEC_LONG, VEC_NOISE} vec_kind_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [CFG_BITS-1:0]         cfg_wr_data;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [ELEM_BITS-1:0] in_element;
  logic                        in_vector_end;
  logic                        out_valid;
  logic                        out_stall;
  logic [ATOM_BITS-1:0]        out_atom_index;
  logic [SUM_BITS-1:0]         out_row_sum;
  logic                        out_final_atom;
  logic                        out_count_mismatch;

  pair_row_square_sum_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_element         (in_element),
    .in_vector_end      (in_vector_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_atom_index     (out_atom_index),
    .out_row_sum        (out_row_sum),
    .out_final_atom     (out_final_atom),
    .out_count_mismatch (out_count_mismatch)
  );

  logic [CFG_BITS-1:0] atom_count_q;
  logic [SUM_BITS-1:0] atom_sum [MAX_ATOMS];
  int unsigned         row_pos_q;
  int unsigned         col_pos_q;
  int unsigned         pairs_q;
  bit                  extra_q;

  row_result_t row_sums_due [$];
  row_result_t due;
  dir_row_t    dir_rows [DIR_ROWS];
  int          phase_counts [NUM_PHASES] = '{5, 2, 3, 64, 4, 96, 7, 1, 6, 10};

  int          errors;
  int          beats_sent;
  int          vectors_done;
  int          sums_checked;
  int          cfg_writes;
  int          long_holds;
  int          burst_left;
  bit          long_hold_req;

  stall_mode_t stall_mode;
  int          mode_left;
  int          stall_phase;

  int          r;
  int          p;
  int          k;
  int          len;
  int          n_cur;
  int          npairs_cur;
  int          phase_items;
  int          rand_items;
  bit          with_end;
  vec_kind_t   kind;
  int unsigned pick;

  function automatic int unsigned atoms_in_use();
    if (atom_count_q < 2) return 2;
    if (atom_count_q > MAX_ATOMS) return MAX_ATOMS;
    return atom_count_q;
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] sum,
                                                  logic [SQ_BITS-1:0] sq);
    logic [SUM_BITS:0] acc;
    acc = sum;
    acc = acc + sq;
    return acc[SUM_BITS] ? {SUM_BITS{1'b1}} : acc[SUM_BITS-1:0];
  endfunction

  function automatic logic [ELEM_BITS-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return ELEM_BITS'($urandom);
    endcase
  endfunction

  task automatic clear_vector_state();
    foreach (atom_sum[i]) atom_sum[i] = '0;
    row_pos_q = 0;
    col_pos_q = 1;
    pairs_q   = 0;
    extra_q   = 1'b0;
  endtask

  task automatic accumulate_beat(input logic [ELEM_BITS-1:0] elem, input bit vend);
    int unsigned          n;
    int unsigned          npairs;
    int unsigned          a;
    logic [ELEM_BITS-1:0] mag;
    logic [SQ_BITS-1:0]   sq;
    bit                   mis;
    n      = atoms_in_use();
    npairs = n * (n - 1) / 2;
    mag    = elem[ELEM_BITS-1] ? -elem : elem;
    sq     = SQ_BITS'(mag) * SQ_BITS'(mag);
    if (pairs_q < npairs && row_pos_q + 1 < n && col_pos_q < n) begin
      atom_sum[row_pos_q] = sat_add(atom_sum[row_pos_q], sq);
      atom_sum[col_pos_q] = sat_add(atom_sum[col_pos_q], sq);
      pairs_q++;
      col_pos_q++;
      if (col_pos_q >= n) begin
        row_pos_q++;
        col_pos_q = row_pos_q + 1;
      end
    end else begin
      extra_q = 1'b1;
    end
    if (vend) begin
      mis = extra_q || (pairs_q != npairs);
      for (a = 0; a < n; a++) begin
        row_sums_due.push_back(row_result_t'{atom_index:     ATOM_BITS'(a),
                                             row_sum:        atom_sum[a],
                                             final_atom:     (a == n - 1),
                                             count_mismatch: mis});
      end
      vectors_done++;
      clear_vector_state();
    end
  endtask

  task automatic send_beat(input logic [ELEM_BITS-1:0] elem, input bit vend);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_element    <= elem;
    in_vector_end <= vend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    accumulate_beat(elem, vend);
  endtask

  task automatic pause_and_settle();
    in_valid <= 1'b0;
    while (row_sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_atom_count(input logic [CFG_BITS-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    atom_count_q  = value;
    cfg_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("pair_row_square_sum_unit test failed");
    $finish;
  end

  initial begin
    out_stall   <= 1'b0;
    mode_left   = 0;
    stall_phase = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        long_holds++;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      stall_phase++;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (row_sums_due.size() == 0) begin
        errors++;
        $display("%0t ns: row sum for atom %0d with nothing expected", $time, out_atom_index);
      end else begin
        due = row_sums_due.pop_front();
        sums_checked++;
        if (out_atom_index !== due.atom_index) begin
          errors++;
          $display("%0t ns: atom_index expected %0d, got %0d",
                   $time, due.atom_index, out_atom_index);
        end
        if (out_row_sum !== due.row_sum) begin
          errors++;
          $display("%0t ns: row_sum of atom %0d expected %h, got %h",
                   $time, due.atom_index, due.row_sum, out_row_sum);
        end
        if (out_final_atom !== due.final_atom) begin
          errors++;
          $display("%0t ns: final_atom of atom %0d expected %b, got %b",
                   $time, due.atom_index, due.final_atom, out_final_atom);
        end
        if (out_count_mismatch !== due.count_mismatch) begin
          errors++;
          $display("%0t ns: count_mismatch of atom %0d expected %b, got %b",
                   $time, due.atom_index, due.count_mismatch, out_count_mismatch);
        end
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_element    <= '0;
    in_vector_end <= 1'b0;
    errors        = 0;
    beats_sent    = 0;
    vectors_done  = 0;
    sums_checked  = 0;
    cfg_writes    = 0;
    long_holds    = 0;
    burst_left    = 0;
    long_hold_req = 1'b0;
    rand_items    = 0;
    atom_count_q  = ATOM_COUNT_RESET;
    clear_vector_state();

    dir_rows = '{
      '{-1,  16'h8000, 1'b1, 1'b1, 36'h040000000, 1'b0},
      '{-1,  16'h7FFF, 1'b1, 1'b1, 36'h03FFF0001, 1'b0},
      '{-1,  16'h0001, 1'b0, 1'b0, 36'h0,         1'b0},
      '{-1,  16'hFFFF, 1'b1, 1'b1, 36'h000000001, 1'b1},
      '{-1,  16'h0000, 1'b0, 1'b0, 36'h0,         1'b0},
      '{-1,  16'h1234, 1'b0, 1'b0, 36'h0,         1'b0},
      '{-1,  16'h7FFF, 1'b1, 1'b1, 36'h000000000, 1'b1},
      '{3,   16'h4000, 1'b0, 1'b0, 36'h0,         1'b0},
      '{-1,  16'hC000, 1'b0, 1'b0, 36'h0,         1'b0},
      '{-1,  16'h2000, 1'b1, 1'b0, 36'h0,         1'b0},
      '{-1,  16'h0000, 1'b1, 1'b1, 36'h000000000, 1'b1},
      '{0,   16'hFFFF, 1'b1, 1'b1, 36'h000000001, 1'b0},
      '{1,   16'h8001, 1'b1, 1'b1, 36'h03FFF0001, 1'b0},
      '{127, 16'h7FFF, 1'b0, 1'b0, 36'h0,         1'b0},
      '{-1,  16'h8000, 1'b1, 1'b0, 36'h0,         1'b0},
      '{65,  16'h5555, 1'b1, 1'b0, 36'h0,         1'b0},
      '{4,   16'h0100, 1'b0, 1'b0, 36'h0,         1'b0},
      '{-1,  16'h0200, 1'b0, 1'b0, 36'h0,         1'b0},
      '{2,   16'h0300, 1'b1, 1'b0, 36'h0,         1'b0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].cfg >= 0) begin
        pause_and_settle();
        write_atom_count(CFG_BITS'(dir_rows[r].cfg));
      end
      send_beat(dir_rows[r].elem, dir_rows[r].vend);
      if (dir_rows[r].typed && dir_rows[r].vend) begin
        n_cur = atoms_in_use();
        repeat (n_cur) void'(row_sums_due.pop_back());
        for (k = 0; k < n_cur; k++) begin
          row_sums_due.push_back(row_result_t'{atom_index:     ATOM_BITS'(k),
                                               row_sum:        dir_rows[r].t_sum,
                                               final_atom:     (k == n_cur - 1),
                                               count_mismatch: dir_rows[r].t_mis});
        end
      end
    end

    p = 0;
    while (p < NUM_PHASES || rand_items < RAND_ITEMS) begin
      pause_and_settle();
      write_atom_count(CFG_BITS'((p < NUM_PHASES) ? phase_counts[p] : $urandom_range(2, 9)));
      if (p == 2) long_hold_req = 1'b1;
      n_cur       = atoms_in_use();
      npairs_cur  = n_cur * (n_cur - 1) / 2;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        kind = (pick < 7) ? VEC_WHOLE : (pick == 7) ? VEC_SHORT :
               (pick == 8) ? VEC_LONG : VEC_NOISE;
        if (n_cur == MAX_ATOMS) kind = VEC_SHORT;
        with_end = 1'b1;
        case (kind)
          VEC_WHOLE: len = npairs_cur;
          VEC_SHORT: len = (n_cur == MAX_ATOMS) ? $urandom_range(1, 8)
                                                : $urandom_range(1, npairs_cur);
          VEC_LONG:  len = npairs_cur + $urandom_range(1, 3);
          default: begin
            len      = $urandom_range(1, 3);
            with_end = 1'b0;
          end
        endcase
        for (k = 0; k < len; k++) begin
          send_beat(rand_elem(), with_end && (k == len - 1));
          phase_items++;
          rand_items++;
        end
      end
      p++;
    end

    in_valid <= 1'b0;
    while (row_sums_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d element beats making %0d vectors; checked %0d row sums.",
             beats_sent, vectors_done, sums_checked);
    $display("Atom count written %0d times, long output hold-offs: %0d, errors: %0d.",
             cfg_writes, long_holds, errors);
    if (errors == 0) begin
      $display("pair_row_square_sum_unit test passed");
    end else begin
      $display("pair_row_square_sum_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
